>>> rtl/core/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types, constants and arithmetic helpers for the two-alphabet
// 2x2 Hill pair cipher.
// ----------------------------------------------------------------------------
package hpc_pkg;

   // Moduli of the two alphabets
   localparam int MOD_LATIN   = 26;
   localparam int MOD_RUSSIAN = 33;

   // Reciprocals for constant reduction: q = (x * R) >> 16, valid for 12-bit x
   localparam logic [11:0] RECIP_LATIN   = 12'd2521;
   localparam logic [11:0] RECIP_RUSSIAN = 12'd1986;

   // Code point ranges
   localparam logic [20:0] LATIN_UPPER_FIRST   = 21'h000041;
   localparam logic [20:0] LATIN_UPPER_LAST    = 21'h00005A;
   localparam logic [20:0] LATIN_LOWER_FIRST   = 21'h000061;
   localparam logic [20:0] LATIN_LOWER_LAST    = 21'h00007A;
   localparam logic [20:0] RUSSIAN_UPPER_FIRST = 21'h000410;
   localparam logic [20:0] RUSSIAN_UPPER_LAST  = 21'h00042F;
   localparam logic [20:0] RUSSIAN_LOWER_FIRST = 21'h000430;
   localparam logic [20:0] RUSSIAN_LOWER_LAST  = 21'h00044F;
   localparam logic [20:0] YO_UPPER            = 21'h000401;
   localparam logic [20:0] YO_LOWER            = 21'h000451;
   localparam logic [5:0]  YO_INDEX            = 6'd6;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ALPHA_NONE,
      ALPHA_LATIN,
      ALPHA_RUSSIAN
   } alpha_type;

   typedef enum logic [2:0] {
      REG_KEY_A,
      REG_KEY_B,
      REG_KEY_C,
      REG_KEY_D,
      REG_DECRYPT_MODE
   } reg_index_type;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_RESIDUE,
      CFG_DET,
      CFG_DETMOD,
      CFG_INVPROD,
      CFG_INVMOD
   } cfg_state_type;

   // Key material handed from the register block to the datapath
   typedef struct packed {
      logic            key_valid;
      logic            decrypt;
      logic [3:0][4:0] enc_latin;
      logic [3:0][4:0] dec_latin;
      logic [3:0][5:0] enc_russian;
      logic [3:0][5:0] dec_russian;
   } key_set_type;

   // Decoded request handed from the front stage to the back stage
   typedef struct packed {
      logic        pair;
      logic        emit_prev;
      logic        emit_cur;
      logic        err;
      logic        russian;
      logic        upper_first;
      logic        upper_second;
      logic [20:0] prev_code;
      logic [20:0] cur_code;
      logic [10:0] prod_a;
      logic [10:0] prod_b;
      logic [10:0] prod_c;
      logic [10:0] prod_d;
   } work_type;

   typedef struct packed {
      logic [20:0] code;
      logic        last;
      logic        err;
   } result_type;

   // Reduce a 12-bit value mod 26
   function automatic logic [4:0] mod_latin(input logic [11:0] x);
      logic [23:0] prod;
      logic [11:0] q;
      logic [11:0] r;
      prod = 24'(x) * 24'(RECIP_LATIN);
      q    = 12'(prod[23:16]);
      r    = x - 12'(q * 12'(MOD_LATIN));
      return r[4:0];
   endfunction

   // Reduce a 12-bit value mod 33
   function automatic logic [5:0] mod_russian(input logic [11:0] x);
      logic [23:0] prod;
      logic [11:0] q;
      logic [11:0] r;
      prod = 24'(x) * 24'(RECIP_RUSSIAN);
      q    = 12'(prod[23:16]);
      r    = x - 12'(q * 12'(MOD_RUSSIAN));
      return r[5:0];
   endfunction

   // Multiplicative inverse mod 26, zero where none exists
   function automatic logic [4:0] inv_latin(input logic [4:0] d);
      logic [4:0] r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Multiplicative inverse mod 33, zero where none exists
   function automatic logic [5:0] inv_russian(input logic [5:0] d);
      logic [5:0] r;
      case (d)
         6'd1:    r = 6'd1;
         6'd2:    r = 6'd17;
         6'd4:    r = 6'd25;
         6'd5:    r = 6'd20;
         6'd7:    r = 6'd19;
         6'd8:    r = 6'd29;
         6'd10:   r = 6'd10;
         6'd13:   r = 6'd28;
         6'd14:   r = 6'd26;
         6'd16:   r = 6'd31;
         6'd17:   r = 6'd2;
         6'd19:   r = 6'd7;
         6'd20:   r = 6'd5;
         6'd23:   r = 6'd23;
         6'd25:   r = 6'd4;
         6'd26:   r = 6'd14;
         6'd28:   r = 6'd13;
         6'd29:   r = 6'd8;
         6'd31:   r = 6'd16;
         6'd32:   r = 6'd32;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/hpc_cfg.sv
// ----------------------------------------------------------------------------
// hpc_cfg
// Register block: key and mode registers on the APB-style port, plus a short
// sequencer that reduces the key and derives the inverse matrices.
// ----------------------------------------------------------------------------
module hpc_cfg
   import hpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        busy,
   output key_set_type keys
);

   logic [9:0]      key_a_ff, key_b_ff, key_c_ff, key_d_ff;
   logic            decrypt_ff;
   cfg_state_type   state_ff, state_in;
   reg_index_type   reg_index;
   logic            wr_strobe;
   logic            wr_known;

   logic [3:0][4:0] k_lat_ff;
   logic [3:0][5:0] k_rus_ff;
   logic [3:0][4:0] inv_lat_ff;
   logic [3:0][5:0] inv_rus_ff;
   logic            key_valid_ff;

   logic [10:0]     det_raw_lat_ff;
   logic [11:0]     det_raw_rus_ff;
   logic [4:0]      det_lat_ff;
   logic [5:0]      det_rus_ff;
   logic [3:0][9:0] iprod_lat_ff;
   logic [3:0][10:0] iprod_rus_ff;
   logic            valid_pend_ff;

   logic [9:0]      ad_lat, bc_lat;
   logic [11:0]     ad_rus, bc_rus;
   logic [4:0]      idet_lat, neg_b_lat, neg_c_lat;
   logic [5:0]      idet_rus, neg_b_rus, neg_c_rus;
   logic [9:0]      ip_lat_0, ip_lat_1, ip_lat_2, ip_lat_3;
   logic [11:0]     ip_rus_0, ip_rus_1, ip_rus_2, ip_rus_3;

   // Decode the write
   assign reg_index = reg_index_type'(paddr[4:2]);
   assign wr_strobe = psel & penable & pwrite;

   always_comb begin
      unique case (reg_index)
         REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_DECRYPT_MODE: wr_known = 1'b1;
         default: wr_known = 1'b0;
      endcase
   end

   // Key and mode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_a_ff   <= 10'd1;
         key_b_ff   <= 10'd0;
         key_c_ff   <= 10'd0;
         key_d_ff   <= 10'd1;
         decrypt_ff <= 1'b0;
      end else if (wr_strobe) begin
         unique case (reg_index)
            REG_KEY_A:        key_a_ff   <= pwdata[9:0];
            REG_KEY_B:        key_b_ff   <= pwdata[9:0];
            REG_KEY_C:        key_c_ff   <= pwdata[9:0];
            REG_KEY_D:        key_d_ff   <= pwdata[9:0];
            REG_DECRYPT_MODE: decrypt_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_KEY_A:        prdata = 32'(key_a_ff);
         REG_KEY_B:        prdata = 32'(key_b_ff);
         REG_KEY_C:        prdata = 32'(key_c_ff);
         REG_KEY_D:        prdata = 32'(key_d_ff);
         REG_DECRYPT_MODE: prdata = 32'(decrypt_ff);
         default:          prdata = 32'd0;
      endcase
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CFG_IDLE:    if (wr_strobe && wr_known) state_in = CFG_RESIDUE;
         CFG_RESIDUE: state_in = CFG_DET;
         CFG_DET:     state_in = CFG_DETMOD;
         CFG_DETMOD:  state_in = CFG_INVPROD;
         CFG_INVPROD: state_in = CFG_INVMOD;
         CFG_INVMOD:  state_in = CFG_IDLE;
         default:     state_in = CFG_IDLE;
      endcase
      // restart on every write to a mapped register so the derived keys follow the last one
      if (wr_strobe && wr_known) state_in = CFG_RESIDUE;
      busy = (state_ff != CFG_IDLE) | wr_strobe;
   end

   // Products for the determinant and the adjugate terms
   always_comb begin
      ad_lat    = 10'(k_lat_ff[0]) * 10'(k_lat_ff[3]);
      bc_lat    = 10'(k_lat_ff[1]) * 10'(k_lat_ff[2]);
      ad_rus    = 12'(k_rus_ff[0]) * 12'(k_rus_ff[3]);
      bc_rus    = 12'(k_rus_ff[1]) * 12'(k_rus_ff[2]);
      idet_lat  = inv_latin(det_lat_ff);
      idet_rus  = inv_russian(det_rus_ff);
      neg_b_lat = (k_lat_ff[1] == 5'd0) ? 5'd0 : 5'(MOD_LATIN) - k_lat_ff[1];
      neg_c_lat = (k_lat_ff[2] == 5'd0) ? 5'd0 : 5'(MOD_LATIN) - k_lat_ff[2];
      neg_b_rus = (k_rus_ff[1] == 6'd0) ? 6'd0 : 6'(MOD_RUSSIAN) - k_rus_ff[1];
      neg_c_rus = (k_rus_ff[2] == 6'd0) ? 6'd0 : 6'(MOD_RUSSIAN) - k_rus_ff[2];
      ip_lat_0  = 10'(idet_lat) * 10'(k_lat_ff[3]);
      ip_lat_1  = 10'(idet_lat) * 10'(neg_b_lat);
      ip_lat_2  = 10'(idet_lat) * 10'(neg_c_lat);
      ip_lat_3  = 10'(idet_lat) * 10'(k_lat_ff[0]);
      ip_rus_0  = 12'(idet_rus) * 12'(k_rus_ff[3]);
      ip_rus_1  = 12'(idet_rus) * 12'(neg_b_rus);
      ip_rus_2  = 12'(idet_rus) * 12'(neg_c_rus);
      ip_rus_3  = 12'(idet_rus) * 12'(k_rus_ff[0]);
   end

   // Sequencer datapath, scratch registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         CFG_DET: begin
            det_raw_lat_ff <= 11'(ad_lat) + 11'(MOD_LATIN * MOD_LATIN) - 11'(bc_lat);
            det_raw_rus_ff <= ad_rus + 12'(MOD_RUSSIAN * MOD_RUSSIAN) - bc_rus;
         end
         CFG_DETMOD: begin
            det_lat_ff <= mod_latin(12'(det_raw_lat_ff));
            det_rus_ff <= mod_russian(det_raw_rus_ff);
         end
         CFG_INVPROD: begin
            iprod_lat_ff[0] <= ip_lat_0;
            iprod_lat_ff[1] <= ip_lat_1;
            iprod_lat_ff[2] <= ip_lat_2;
            iprod_lat_ff[3] <= ip_lat_3;
            iprod_rus_ff[0] <= ip_rus_0[10:0];
            iprod_rus_ff[1] <= ip_rus_1[10:0];
            iprod_rus_ff[2] <= ip_rus_2[10:0];
            iprod_rus_ff[3] <= ip_rus_3[10:0];
            valid_pend_ff   <= (idet_lat != 5'd0) && (idet_rus != 6'd0);
         end
         default: ;
      endcase
   end

   // Derived key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_lat_ff     <= {5'd1, 5'd0, 5'd0, 5'd1};
         k_rus_ff     <= {6'd1, 6'd0, 6'd0, 6'd1};
         inv_lat_ff   <= {5'd1, 5'd0, 5'd0, 5'd1};
         inv_rus_ff   <= {6'd1, 6'd0, 6'd0, 6'd1};
         key_valid_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            CFG_RESIDUE: begin
               k_lat_ff[0] <= mod_latin(12'(key_a_ff));
               k_lat_ff[1] <= mod_latin(12'(key_b_ff));
               k_lat_ff[2] <= mod_latin(12'(key_c_ff));
               k_lat_ff[3] <= mod_latin(12'(key_d_ff));
               k_rus_ff[0] <= mod_russian(12'(key_a_ff));
               k_rus_ff[1] <= mod_russian(12'(key_b_ff));
               k_rus_ff[2] <= mod_russian(12'(key_c_ff));
               k_rus_ff[3] <= mod_russian(12'(key_d_ff));
            end
            CFG_INVMOD: begin
               key_valid_ff <= valid_pend_ff;
               if (valid_pend_ff) begin
                  inv_lat_ff[0] <= mod_latin(12'(iprod_lat_ff[0]));
                  inv_lat_ff[1] <= mod_latin(12'(iprod_lat_ff[1]));
                  inv_lat_ff[2] <= mod_latin(12'(iprod_lat_ff[2]));
                  inv_lat_ff[3] <= mod_latin(12'(iprod_lat_ff[3]));
                  inv_rus_ff[0] <= mod_russian(12'(iprod_rus_ff[0]));
                  inv_rus_ff[1] <= mod_russian(12'(iprod_rus_ff[1]));
                  inv_rus_ff[2] <= mod_russian(12'(iprod_rus_ff[2]));
                  inv_rus_ff[3] <= mod_russian(12'(iprod_rus_ff[3]));
               end else begin
                  inv_lat_ff <= {5'd1, 5'd0, 5'd0, 5'd1};
                  inv_rus_ff <= {6'd1, 6'd0, 6'd0, 6'd1};
               end
            end
            default: ;
         endcase
      end
   end

   // Hand the key set to the datapath
   always_comb begin
      keys.key_valid   = key_valid_ff;
      keys.decrypt     = decrypt_ff;
      keys.enc_latin   = k_lat_ff;
      keys.dec_latin   = inv_lat_ff;
      keys.enc_russian = k_rus_ff;
      keys.dec_russian = inv_rus_ff;
   end

endmodule

>>> rtl/core/hpc_front.sv
// ----------------------------------------------------------------------------
// hpc_front
// Input register, letter classification, pairing against the held letter and
// the four matrix products of a pair.
// ----------------------------------------------------------------------------
module hpc_front
   import hpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        accept,
   input  logic [20:0] code_in,
   input  logic        end_of_text,
   input  key_set_type keys,
   output logic        work_valid,
   output work_type    work
);

   logic        in_valid_ff;
   logic [20:0] in_code_ff;
   logic        in_eot_ff;

   logic        held_valid_ff, held_valid_in;
   logic [20:0] held_code_ff, held_code_in;
   logic        held_russian_ff, held_russian_in;
   logic        held_upper_ff, held_upper_in;
   logic [5:0]  held_index_ff, held_index_in;

   logic        work_valid_ff;
   work_type    work_ff, work_in;

   alpha_type       alpha;
   logic            upper;
   logic [5:0]      index;
   logic [5:0]      offset;
   logic            is_russian;
   logic [3:0][5:0] k;

   function automatic logic [10:0] mul_idx(input logic [5:0] a, input logic [5:0] b);
      logic [11:0] p;
      p = 12'(a) * 12'(b);
      return p[10:0];
   endfunction

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && accept) begin
         in_code_ff <= code_in;
         in_eot_ff  <= end_of_text;
      end
   end

   // Classify the letter
   always_comb begin
      alpha  = ALPHA_NONE;
      upper  = 1'b0;
      index  = 6'd0;
      offset = 6'd0;
      if (in_code_ff >= LATIN_UPPER_FIRST && in_code_ff <= LATIN_UPPER_LAST) begin
         alpha = ALPHA_LATIN;
         upper = 1'b1;
         index = 6'(in_code_ff - LATIN_UPPER_FIRST);
      end else if (in_code_ff >= LATIN_LOWER_FIRST && in_code_ff <= LATIN_LOWER_LAST) begin
         alpha = ALPHA_LATIN;
         index = 6'(in_code_ff - LATIN_LOWER_FIRST);
      end else if (in_code_ff == YO_UPPER) begin
         alpha = ALPHA_RUSSIAN;
         upper = 1'b1;
         index = YO_INDEX;
      end else if (in_code_ff == YO_LOWER) begin
         alpha = ALPHA_RUSSIAN;
         index = YO_INDEX;
      end else if (in_code_ff >= RUSSIAN_UPPER_FIRST && in_code_ff <= RUSSIAN_UPPER_LAST) begin
         alpha  = ALPHA_RUSSIAN;
         upper  = 1'b1;
         offset = 6'(in_code_ff - RUSSIAN_UPPER_FIRST);
         index  = (offset >= YO_INDEX) ? offset + 6'd1 : offset;
      end else if (in_code_ff >= RUSSIAN_LOWER_FIRST && in_code_ff <= RUSSIAN_LOWER_LAST) begin
         alpha  = ALPHA_RUSSIAN;
         offset = 6'(in_code_ff - RUSSIAN_LOWER_FIRST);
         index  = (offset >= YO_INDEX) ? offset + 6'd1 : offset;
      end
      is_russian = (alpha == ALPHA_RUSSIAN);
   end

   // Pick the matrix for this alphabet and direction
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (is_russian) begin
            k[i] = keys.decrypt ? keys.dec_russian[i] : keys.enc_russian[i];
         end else begin
            k[i] = keys.decrypt ? 6'(keys.dec_latin[i]) : 6'(keys.enc_latin[i]);
         end
      end
   end

   // Pair against the held letter and update the hold
   always_comb begin
      held_valid_in   = held_valid_ff;
      held_code_in    = held_code_ff;
      held_russian_in = held_russian_ff;
      held_upper_in   = held_upper_ff;
      held_index_in   = held_index_ff;

      work_in              = '0;
      work_in.russian      = is_russian;
      work_in.upper_first  = held_upper_ff;
      work_in.upper_second = upper;
      work_in.prev_code    = held_code_ff;
      work_in.cur_code     = in_code_ff;
      work_in.prod_a       = mul_idx(k[0], held_index_ff);
      work_in.prod_b       = mul_idx(k[1], index);
      work_in.prod_c       = mul_idx(k[2], held_index_ff);
      work_in.prod_d       = mul_idx(k[3], index);

      if (in_valid_ff) begin
         if (!keys.key_valid) begin
            // bad key: drain the hold and pass everything through flagged
            work_in.emit_prev = held_valid_ff;
            work_in.emit_cur  = 1'b1;
            work_in.err       = 1'b1;
            held_valid_in     = 1'b0;
         end else if (alpha == ALPHA_NONE) begin
            work_in.emit_prev = held_valid_ff;
            work_in.emit_cur  = 1'b1;
            held_valid_in     = 1'b0;
         end else if (!held_valid_ff || (held_russian_ff != is_russian)) begin
            // start a new hold; flush it straight away at end of text
            work_in.emit_prev = held_valid_ff;
            work_in.emit_cur  = in_eot_ff;
            held_valid_in     = !in_eot_ff;
            held_code_in      = in_code_ff;
            held_russian_in   = is_russian;
            held_upper_in     = upper;
            held_index_in     = index;
         end else begin
            work_in.pair  = 1'b1;
            held_valid_in = 1'b0;
         end
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (adv) begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         held_code_ff    <= held_code_in;
         held_russian_ff <= held_russian_in;
         held_upper_ff   <= held_upper_in;
         held_index_ff   <= held_index_in;
      end
   end

   // Stage register towards the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else if (adv) begin
         work_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         work_ff <= work_in;
      end
   end

   assign work_valid = work_valid_ff;
   assign work       = work_ff;

endmodule

>>> rtl/core/hpc_back.sv
// ----------------------------------------------------------------------------
// hpc_back
// Modular reduction of the pair sums, code point rebuild and the result
// queue that decouples the two channels.
// ----------------------------------------------------------------------------
module hpc_back
   import hpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        work_valid,
   input  work_type    work,
   input  logic        rsp_stall,
   output logic        adv,
   output logic        rsp_valid,
   output logic [20:0] rsp_code_out,
   output logic        rsp_last_of_run,
   output logic        rsp_key_error
);

   result_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff, wr_next;
   logic [QUEUE_CNT_W-1:0]     count_ff, after_pop;
   logic                       pop;
   logic [1:0]                 push_n;
   logic [1:0]                 result_n;
   logic [11:0]                sum_first, sum_second;
   logic [5:0]                 y_first, y_second;
   result_type                 slot0, slot1;

   function automatic logic [20:0] make_code(input logic russian, input logic upper,
                                             input logic [5:0] idx);
      logic [20:0] base;
      logic [20:0] r;
      if (!russian) begin
         base = upper ? LATIN_UPPER_FIRST : LATIN_LOWER_FIRST;
         r    = base + 21'(idx);
      end else if (idx == YO_INDEX) begin
         r = upper ? YO_UPPER : YO_LOWER;
      end else begin
         base = upper ? RUSSIAN_UPPER_FIRST : RUSSIAN_LOWER_FIRST;
         r    = (idx < YO_INDEX) ? base + 21'(idx) : base + 21'(idx) - 21'd1;
      end
      return r;
   endfunction

   // Reduce the pair sums
   always_comb begin
      sum_first  = 12'(work.prod_a) + 12'(work.prod_b);
      sum_second = 12'(work.prod_c) + 12'(work.prod_d);
      if (work.russian) begin
         y_first  = mod_russian(sum_first);
         y_second = mod_russian(sum_second);
      end else begin
         y_first  = 6'(mod_latin(sum_first));
         y_second = 6'(mod_latin(sum_second));
      end
   end

   // Build up to two results in text order
   always_comb begin
      slot0     = '0;
      slot1     = '0;
      slot0.err = work.err;
      slot1.err = work.err;
      result_n  = 2'd0;
      if (work.pair) begin
         slot0.code = make_code(work.russian, work.upper_first, y_first);
         slot1.code = make_code(work.russian, work.upper_second, y_second);
         slot1.last = 1'b1;
         result_n   = 2'd2;
      end else if (work.emit_prev && work.emit_cur) begin
         slot0.code = work.prev_code;
         slot1.code = work.cur_code;
         slot1.last = 1'b1;
         result_n   = 2'd2;
      end else if (work.emit_prev) begin
         slot0.code = work.prev_code;
         slot0.last = 1'b1;
         result_n   = 2'd1;
      end else if (work.emit_cur) begin
         slot0.code = work.cur_code;
         slot0.last = 1'b1;
         result_n   = 2'd1;
      end
   end

   // Advance the pipe only while the queue can take two more results
   always_comb begin
      rsp_valid = (count_ff != '0);
      pop       = rsp_valid & ~rsp_stall;
      after_pop = count_ff - QUEUE_CNT_W'(pop);
      adv       = (after_pop <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
      push_n    = (adv && work_valid) ? result_n : 2'd0;
      wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);
   end

   // Queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(pop);
         count_ff  <= after_pop + QUEUE_CNT_W'(push_n);
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_next] <= slot1;
      end
   end

   assign rsp_code_out    = entries_ff[rd_ptr_ff].code;
   assign rsp_last_of_run = entries_ff[rd_ptr_ff].last;
   assign rsp_key_error   = entries_ff[rd_ptr_ff].err;

endmodule

>>> rtl/core/hill_pair_cipher_two_alphabets.sv
// ----------------------------------------------------------------------------
// hill_pair_cipher_two_alphabets
// 2x2 Hill cipher over pairs of Latin or Russian letters in a code point stream.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid / req_stall) takes one code point and an
// end-of-text flag per request. The result channel (rsp_valid / rsp_stall)
// gives code points in text order, each with a last-of-run flag for the
// final result a request caused and a key error flag.
// One request is taken every cycle while req_stall is low. A result passes the
// input register, the pairing and products stage, then reduction into a
// four-entry result queue. The queue sets the rate: the pipe advances while
// at most two entries would remain after this cycle's read, so one result per
// cycle leaves the block when the receiver keeps up.
// A stall on the result channel fills the queue; req_stall then rises and
// the pipe holds. The first letter of a pair is held and gives no result until
// its partner, a letter of the other alphabet, a non-letter or end of text arrives.
// Each write to a mapped register on the APB-style port starts, or restarts, a key
// update (residues, determinant, inverse); req_stall is high from the write's
// access cycle until the update ends.
// Reset restores the identity key in encrypt mode and empties the queue and hold.
// ----------------------------------------------------------------------------
module hill_pair_cipher_two_alphabets
   import hpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [20:0] req_code_in,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_out,
   output logic        rsp_last_of_run,
   output logic        rsp_key_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   key_set_type keys;
   logic        cfg_busy;
   logic        adv;
   logic        accept;
   logic        work_valid;
   work_type    work;

   assign pready    = 1'b1;
   assign req_stall = ~adv | cfg_busy;
   assign accept    = req_valid & ~req_stall;

   hpc_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .busy    (cfg_busy),
      .keys    (keys)
   );

   hpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .code_in     (req_code_in),
      .end_of_text (req_end_of_text),
      .keys        (keys),
      .work_valid  (work_valid),
      .work        (work)
   );

   hpc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .work_valid      (work_valid),
      .work            (work),
      .rsp_stall       (rsp_stall),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_code_out    (rsp_code_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_key_error   (rsp_key_error)
   );

endmodule

>>> tb/hill_pair_cipher_two_alphabets_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hill_pair_cipher_two_alphabets_tb
// Self-checking bench for the two-alphabet 2x2 Hill pair cipher.
// A queue of code points feeds a clocked driver; every accepted request is run
// through a local cipher predictor whose results wait in order until the
// clocked monitor compares them with the result channel. Keys and mode are
// set over the APB-style port between phases, each mapped register write read back.
// ----------------------------------------------------------------------------
module hill_pair_cipher_two_alphabets_tb
   import hpc_pkg::*;
();

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int RANDOM_PHASES   = 16;
   localparam int ITEMS_PER_PHASE = 100;
   // Aligned address past the last register
   localparam logic [4:0] SPARE_ADDR = 5'd20;

   typedef struct packed {
      logic [20:0] code;
      logic        eot;
   } symbol_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [20:0] req_code_in     = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [20:0] rsp_code_out;
   logic        rsp_last_of_run;
   logic        rsp_key_error;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [4:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;
   logic [31:0] prdata;
   logic        pready;

   // Text waiting to be sent and cipher output waiting to be seen
   symbol_type text_q[$];
   result_type cipher_out_q[$];

   // Predictor copy of the key registers and the pairing hold
   int          key_a = 1, key_b = 0, key_c = 0, key_d = 1;
   logic        decrypt = 1'b0;
   logic        key_ok;
   int          inv_key [2][4];
   logic        hold_valid = 1'b0;
   logic [20:0] hold_code  = '0;
   alpha_type   hold_alpha = ALPHA_NONE;
   logic        hold_upper = 1'b0;
   int          hold_index = 0;

   int          send_idle_pct = 31;
   int          recv_idle_pct = 57;
   int          fail_count    = 0;
   int          requests_sent = 0;
   int          results_seen  = 0;
   int          key_settings  = 0;
   int          cycle_count   = 0;
   symbol_type  next_symbol;
   result_type  want;
   alpha_type   run_alpha = ALPHA_LATIN;
   int          cand [4];
   logic        want_valid;

   hill_pair_cipher_two_alphabets i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_in     (req_code_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_out    (rsp_code_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_key_error   (rsp_key_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Inverse of the determinant mod m, zero when there is none
   function automatic int inverse_det(int a, int b, int c, int d, int m);
      int det;
      int idet;
      det  = ((a % m) * (d % m) + m * m - (b % m) * (c % m)) % m;
      idet = 0;
      for (int i = m - 1; i > 0; i--) begin
         if ((det * i) % m == 1) idet = i;
      end
      return idet;
   endfunction

   function automatic logic key_valid_for(int a, int b, int c, int d);
      return inverse_det(a, b, c, d, MOD_LATIN) != 0 &&
             inverse_det(a, b, c, d, MOD_RUSSIAN) != 0;
   endfunction

   // Rebuild validity and the inverse matrices (index 0 Latin, 1 Russian)
   function automatic void refresh_key_tables();
      int m;
      int idet;
      key_ok = 1'b1;
      for (int j = 0; j < 2; j++) begin
         m    = (j == 1) ? MOD_RUSSIAN : MOD_LATIN;
         idet = inverse_det(key_a, key_b, key_c, key_d, m);
         if (idet == 0) key_ok = 1'b0;
         inv_key[j][0] = (idet * (key_d % m)) % m;
         inv_key[j][1] = (idet * ((m - key_b % m) % m)) % m;
         inv_key[j][2] = (idet * ((m - key_c % m) % m)) % m;
         inv_key[j][3] = (idet * (key_a % m)) % m;
      end
   endfunction

   function automatic alpha_type classify_letter(input logic [20:0] code,
                                                 output logic upper, output int idx);
      upper = 1'b0;
      idx   = 0;
      if (code >= LATIN_UPPER_FIRST && code <= LATIN_UPPER_LAST) begin
         upper = 1'b1;
         idx   = int'(code - LATIN_UPPER_FIRST);
         return ALPHA_LATIN;
      end
      if (code >= LATIN_LOWER_FIRST && code <= LATIN_LOWER_LAST) begin
         idx = int'(code - LATIN_LOWER_FIRST);
         return ALPHA_LATIN;
      end
      if (code == YO_UPPER || code == YO_LOWER) begin
         upper = (code == YO_UPPER);
         idx   = int'(YO_INDEX);
         return ALPHA_RUSSIAN;
      end
      if (code >= RUSSIAN_UPPER_FIRST && code <= RUSSIAN_LOWER_LAST) begin
         upper = (code <= RUSSIAN_UPPER_LAST);
         idx   = upper ? int'(code - RUSSIAN_UPPER_FIRST) : int'(code - RUSSIAN_LOWER_FIRST);
         // Yo sits at index 6, so the rest of the block shifts up by one
         if (idx >= YO_INDEX) idx++;
         return ALPHA_RUSSIAN;
      end
      return ALPHA_NONE;
   endfunction

   function automatic logic [20:0] build_letter(alpha_type alpha, logic upper, int idx);
      if (alpha == ALPHA_LATIN)
         return (upper ? LATIN_UPPER_FIRST : LATIN_LOWER_FIRST) + 21'(idx);
      if (idx == YO_INDEX) return upper ? YO_UPPER : YO_LOWER;
      if (idx < YO_INDEX)
         return (upper ? RUSSIAN_UPPER_FIRST : RUSSIAN_LOWER_FIRST) + 21'(idx);
      return (upper ? RUSSIAN_UPPER_FIRST : RUSSIAN_LOWER_FIRST) + 21'(idx - 1);
   endfunction

   function automatic result_type to_result(logic [20:0] code, logic err);
      result_type r;
      r.code = code;
      r.last = 1'b0;
      r.err  = err;
      return r;
   endfunction

   // Work out the cipher output of one request and queue it
   function automatic void predict_cipher(input logic [20:0] code, input logic eot);
      result_type outs[$];
      alpha_type  alpha;
      logic       upper;
      int         idx;
      int         m;
      int         j;
      int         y1;
      int         y2;
      int         k [4];
      if (!key_ok) begin
         // Non-invertible key: flush the hold, pass everything with the error flag
         if (hold_valid) outs.insert(outs.size(), to_result(hold_code, 1'b1));
         hold_valid = 1'b0;
         outs.insert(outs.size(), to_result(code, 1'b1));
      end else begin
         alpha = classify_letter(code, upper, idx);
         if (alpha == ALPHA_NONE) begin
            if (hold_valid) outs.insert(outs.size(), to_result(hold_code, 1'b0));
            hold_valid = 1'b0;
            outs.insert(outs.size(), to_result(code, 1'b0));
         end else if (!hold_valid || hold_alpha != alpha) begin
            // Start a new pair, releasing a letter of the other alphabet
            if (hold_valid) outs.insert(outs.size(), to_result(hold_code, 1'b0));
            hold_valid = 1'b1;
            hold_code  = code;
            hold_alpha = alpha;
            hold_upper = upper;
            hold_index = idx;
         end else begin
            j = (alpha == ALPHA_RUSSIAN) ? 1 : 0;
            m = (j == 1) ? MOD_RUSSIAN : MOD_LATIN;
            if (decrypt) begin
               k = inv_key[j];
            end else begin
               k[0] = key_a % m;
               k[1] = key_b % m;
               k[2] = key_c % m;
               k[3] = key_d % m;
            end
            y1 = (k[0] * hold_index + k[1] * idx) % m;
            y2 = (k[2] * hold_index + k[3] * idx) % m;
            outs.insert(outs.size(), to_result(build_letter(alpha, hold_upper, y1), 1'b0));
            outs.insert(outs.size(), to_result(build_letter(alpha, upper, y2), 1'b0));
            hold_valid = 1'b0;
         end
         if (eot && hold_valid) begin
            outs.insert(outs.size(), to_result(hold_code, 1'b0));
            hold_valid = 1'b0;
         end
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) cipher_out_q.insert(cipher_out_q.size(), outs[i]);
   endfunction

   function automatic void check_field(string what, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, what, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // Random text: mostly letter runs in one alphabet, with switches and noise
   function automatic symbol_type pick_symbol(inout alpha_type cur_alpha);
      symbol_type s;
      int         roll;
      int         idx;
      logic       up;
      roll = $urandom_range(99);
      if ($urandom_range(99) < 20)
         cur_alpha = (cur_alpha == ALPHA_LATIN) ? ALPHA_RUSSIAN : ALPHA_LATIN;
      up  = 1'($urandom_range(1));
      idx = (cur_alpha == ALPHA_LATIN) ? $urandom_range(MOD_LATIN - 1)
                                       : $urandom_range(MOD_RUSSIAN - 1);
      if (roll < 78) begin
         s.code = build_letter(cur_alpha, up, idx);
      end else if (roll < 88) begin
         s.code = 21'($urandom_range(32'h40, 32'h20));
      end else if (roll < 95) begin
         s.code = 21'($urandom);
      end else begin
         // Codes just outside the letter blocks
         case ($urandom_range(7))
            0:       s.code = LATIN_UPPER_FIRST - 21'd1;
            1:       s.code = LATIN_UPPER_LAST + 21'd1;
            2:       s.code = LATIN_LOWER_FIRST - 21'd1;
            3:       s.code = LATIN_LOWER_LAST + 21'd1;
            4:       s.code = YO_UPPER - 21'd1;
            5:       s.code = YO_UPPER + 21'd1;
            6:       s.code = RUSSIAN_UPPER_FIRST - 21'd1;
            default: s.code = YO_LOWER + 21'd1;
         endcase
      end
      s.eot = ($urandom_range(99) < 4);
      return s;
   endfunction

   function automatic logic [4:0] reg_addr(reg_index_type r);
      return {r, 2'b00};
   endfunction

   task automatic queue_symbol(input logic [20:0] code, input logic eot);
      symbol_type s;
      s.code = code;
      s.eot  = eot;
      text_q.insert(text_q.size(), s);
   endtask

   // Wait until the text is sent, all output seen and the pipe has emptied
   task automatic wait_for_drain();
      while (text_q.size() != 0 || req_valid || cipher_out_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, update the predictor, then read it back if it is mapped
   task automatic csr_set(input logic [4:0] addr, input int value);
      logic known;
      int   stored;
      known  = 1'b1;
      stored = value & 32'h3FF;
      case (reg_index_type'(addr[4:2]))
         REG_KEY_A:        key_a = stored;
         REG_KEY_B:        key_b = stored;
         REG_KEY_C:        key_c = stored;
         REG_KEY_D:        key_d = stored;
         REG_DECRYPT_MODE: begin
            stored  = value & 1;
            decrypt = stored[0];
         end
         default:          known = 1'b0;
      endcase
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      refresh_key_tables();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (known) begin
         @(posedge clock);
         psel <= 1'b1;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         check_field("register readback", 32'(stored), prdata);
         psel    <= 1'b0;
         penable <= 1'b0;
      end
   endtask

   task automatic load_key(input int a, input int b, input int c, input int d,
                           input int dec);
      wait_for_drain();
      csr_set(reg_addr(REG_KEY_A), a);
      csr_set(reg_addr(REG_KEY_B), b);
      csr_set(reg_addr(REG_KEY_C), c);
      csr_set(reg_addr(REG_KEY_D), d);
      csr_set(reg_addr(REG_DECRYPT_MODE), dec);
      key_settings++;
   endtask

   // Request driver: predict on acceptance, then offer the next symbol or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_cipher(req_code_in, req_end_of_text);
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_symbol = text_q.pop_front();
               req_valid       <= 1'b1;
               req_code_in     <= next_symbol.code;
               req_end_of_text <= next_symbol.eot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random back-pressure, compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (cipher_out_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual code 0x%0h",
                        $time, rsp_code_out);
               fail_count++;
            end else begin
               want = cipher_out_q.pop_front();
               check_field("code_out", 32'(want.code), 32'(rsp_code_out));
               check_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
               check_field("key_error", 32'(want.err), 32'(rsp_key_error));
               results_seen++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("hill_pair_cipher_two_alphabets verification failed");
         $finish;
      end
   end

   initial begin
      refresh_key_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset key is the identity: a pair comes back unchanged
      queue_symbol(21'h48, 1'b0);
      queue_symbol(21'h69, 1'b0);

      // Invertible key, encrypt: alphabet extremes, Yo, mixed runs, end of text
      load_key(5, 17, 4, 15, 0);
      queue_symbol(LATIN_UPPER_FIRST, 1'b0);
      queue_symbol(LATIN_UPPER_LAST, 1'b0);
      queue_symbol(LATIN_LOWER_FIRST, 1'b0);
      queue_symbol(LATIN_LOWER_LAST, 1'b0);
      queue_symbol(RUSSIAN_UPPER_FIRST, 1'b0);
      queue_symbol(RUSSIAN_UPPER_LAST, 1'b0);
      queue_symbol(YO_UPPER, 1'b0);
      queue_symbol(YO_LOWER, 1'b0);
      queue_symbol(RUSSIAN_LOWER_FIRST, 1'b0);
      queue_symbol(RUSSIAN_LOWER_LAST, 1'b0);
      queue_symbol(21'h51, 1'b0);        // Latin letter then a Russian one
      queue_symbol(21'h416, 1'b0);
      queue_symbol(21'h2E, 1'b0);        // non-letter releases the hold
      queue_symbol(21'h6B, 1'b1);        // lone letter flushed at end of text
      queue_symbol(21'h0, 1'b0);
      queue_symbol(21'h1FFFFF, 1'b0);    // beyond the code point range
      queue_symbol(21'h418, 1'b0);
      queue_symbol(21'h4D, 1'b1);        // alphabet switch and flush together
      queue_symbol(21'h48, 1'b0);        // left held across the mode change

      // Decrypt with the inverse key, pairing with the held letter
      load_key(5, 17, 4, 15, 1);
      queue_symbol(21'h69, 1'b0);
      queue_symbol(21'h412, 1'b0);
      queue_symbol(YO_LOWER, 1'b0);
      queue_symbol(21'h70, 1'b0);        // held into the bad key

      // Non-invertible key: hold flushed, every request flagged
      load_key(0, 0, 0, 0, 0);
      queue_symbol(21'h21, 1'b0);
      queue_symbol(21'h420, 1'b1);

      // Write outside the register map, then keys above the residue range
      wait_for_drain();
      csr_set(SPARE_ADDR, 32'h3FF);
      load_key(1023, 1, 1000, 857, 0);
      queue_symbol(21'h4D, 1'b0);
      queue_symbol(21'h65, 1'b0);
      queue_symbol(21'h415, 1'b1);
      load_key(857, 857, 857, 857, 1);
      queue_symbol(21'h41, 1'b0);

      // Random phases, each under a fresh key setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 31;
            recv_idle_pct = 57;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         want_valid = ($urandom_range(99) < 80);
         do begin
            foreach (cand[i]) cand[i] = $urandom_range(1023);
         end while (want_valid && !key_valid_for(cand[0], cand[1], cand[2], cand[3]));
         load_key(cand[0], cand[1], cand[2], cand[3], $urandom_range(1));
         repeat (ITEMS_PER_PHASE) text_q.insert(text_q.size(), pick_symbol(run_alpha));
      end

      wait_for_drain();
      $display("Checked %0d results from %0d requests under %0d key settings,",
               results_seen, requests_sent, key_settings);
      $display("covering encrypt, decrypt, non-invertible keys and end-of-text flushes.");
      if (fail_count == 0) begin
         $display("hill_pair_cipher_two_alphabets verification clean");
      end else begin
         $display("hill_pair_cipher_two_alphabets verification failed");
      end
      $finish;
   end

endmodule

>>> hill_pair_cipher_two_alphabets.f
rtl/core/hpc_pkg.sv
rtl/core/hpc_cfg.sv
rtl/core/hpc_front.sv
rtl/core/hpc_back.sv
rtl/core/hill_pair_cipher_two_alphabets.sv
tb/hill_pair_cipher_two_alphabets_tb.sv
